FILE: rtl/opd_pkg.sv
// ----------------------------------------------------------------------------
// Ogg page deframer package
// Shared codes, header layout and the capture pattern.
// ----------------------------------------------------------------------------
package opd_pkg;

   localparam int COUNT_WIDTH_DEF = 32;

   // byte kind codes, also used as parse phase codes
   localparam logic [2:0] KIND_SIG  = 3'd0;
   localparam logic [2:0] KIND_HDR  = 3'd1;
   localparam logic [2:0] KIND_LACE = 3'd2;
   localparam logic [2:0] KIND_PAY  = 3'd3;
   localparam logic [2:0] KIND_IGN  = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_BAD   = 2'd1;
   localparam logic [1:0] ST_TRUNC = 2'd2;

   // header byte positions after the capture pattern
   localparam logic [4:0] HDR_VERSION = 5'd0;
   localparam logic [4:0] HDR_FLAGS   = 5'd1;
   localparam logic [4:0] HDR_GRAN    = 5'd2;
   localparam logic [4:0] HDR_SERIAL  = 5'd10;
   localparam logic [4:0] HDR_SEQ     = 5'd14;
   localparam logic [4:0] HDR_CRC     = 5'd18;
   localparam logic [4:0] HDR_SEGS    = 5'd22;
   localparam logic [4:0] SIG_LAST    = 5'd3;

   // capture pattern "OggS"
   function automatic logic [7:0] sig_byte(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = 8'h4F;
         2'd1:    val = 8'h67;
         2'd2:    val = 8'h67;
         default: val = 8'h53;
      endcase
      return val;
   endfunction

endpackage

FILE: rtl/ogg_page_deframer.sv
// ----------------------------------------------------------------------------
// Ogg page deframer
// Parses an Ogg stream byte by byte: capture pattern, header fields, lacing
// table and payload, with one result item per input item.
// ----------------------------------------------------------------------------
// An accepted req item's rsp item is registered and appears in the cycle after it is accepted.
// Throughput: one item per cycle; the parse state and the result register
// update together, so only a stalled, unread result holds off the input.
// Reset (synchronous, active high) returns to the capture-pattern phase,
// clears the captured fields, the byte counter and the sticky error.
// ----------------------------------------------------------------------------
module ogg_page_deframer
   import opd_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   input  logic        req_end_of_data,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_byte_kind,
   output logic        rsp_page_end,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_bytes_consumed,
   output logic [7:0]  rsp_stream_version,
   output logic [7:0]  rsp_header_flags,
   output logic [63:0] rsp_granule_pos,
   output logic [31:0] rsp_serial_no,
   output logic [31:0] rsp_page_seq,
   output logic [31:0] rsp_page_crc,
   output logic [7:0]  rsp_segment_count
);

   // ---------------------------------------------------------------------
   // Parse state. The phase register doubles as the sticky error flag:
   // once it holds the ignore code only reset leaves it.
   // ---------------------------------------------------------------------
   logic [2:0]             phase_ff,    phase_in;
   logic [4:0]             hdr_idx_ff,  hdr_idx_in;
   logic [7:0]             lace_ff,     lace_in;
   logic [15:0]            pay_ff,      pay_in;
   logic [7:0]             version_ff,  version_in;
   logic [7:0]             flags_ff,    flags_in;
   logic [63:0]            granule_ff,  granule_in;
   logic [31:0]            serial_ff,   serial_in;
   logic [31:0]            seq_ff,      seq_in;
   logic [31:0]            crc_ff,      crc_in;
   logic [7:0]             segs_ff,     segs_in;
   logic [COUNT_WIDTH-1:0] count_ff,    count_in;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic [2:0]  out_kind_ff,  out_kind_in;
   logic        out_pend_ff,  out_pend_in;
   logic [1:0]  out_status_ff, out_status_in;
   logic [31:0] out_count_ff, out_count_in;

   logic        accept;
   logic        taken;
   logic        consumed;
   logic [4:0]  gran_off;
   logic [4:0]  serial_off;
   logic [4:0]  seq_off;
   logic [4:0]  crc_off;
   logic [7:0]  lace_dec;
   logic [15:0] pay_sum;
   logic [15:0] pay_dec;
   logic [63:0] count_wide;

   // Hold the input while a finished result sits unread downstream.
   assign req_stall = out_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign taken     = out_valid_ff & ~rsp_stall;

   // byte lane offsets inside the multi-byte little-endian fields
   assign gran_off   = hdr_idx_ff - HDR_GRAN;
   assign serial_off = hdr_idx_ff - HDR_SERIAL;
   assign seq_off    = hdr_idx_ff - HDR_SEQ;
   assign crc_off    = hdr_idx_ff - HDR_CRC;

   assign lace_dec = lace_ff - 8'd1;
   assign pay_sum  = pay_ff + {8'd0, req_byte_in};
   assign pay_dec  = pay_ff - 16'd1;

   // ---------------------------------------------------------------------
   // Next-state logic for one byte
   // ---------------------------------------------------------------------
   always_comb begin
      phase_in    = phase_ff;
      hdr_idx_in  = hdr_idx_ff;
      lace_in     = lace_ff;
      pay_in      = pay_ff;
      version_in  = version_ff;
      flags_in    = flags_ff;
      granule_in  = granule_ff;
      serial_in   = serial_ff;
      seq_in      = seq_ff;
      crc_in      = crc_ff;
      segs_in     = segs_ff;
      out_kind_in = KIND_IGN;
      out_pend_in = 1'b0;
      consumed    = 1'b1;

      case (phase_ff)
         KIND_SIG: begin
            out_kind_in = KIND_SIG;
            if (req_byte_in != sig_byte(hdr_idx_ff[1:0])) begin
               // bad pattern byte: go sticky, do not count it
               phase_in = KIND_IGN;
               consumed = 1'b0;
            end else if (hdr_idx_ff >= SIG_LAST) begin
               hdr_idx_in = '0;
               phase_in   = KIND_HDR;
            end else begin
               hdr_idx_in = hdr_idx_ff + 5'd1;
            end
         end
         KIND_HDR: begin
            out_kind_in = KIND_HDR;
            // overwrite this byte's lane of its field
            if (hdr_idx_ff == HDR_VERSION) begin
               version_in = req_byte_in;
            end else if (hdr_idx_ff == HDR_FLAGS) begin
               flags_in = req_byte_in;
            end else if (hdr_idx_ff < HDR_SERIAL) begin
               granule_in[{gran_off[2:0], 3'b000} +: 8] = req_byte_in;
            end else if (hdr_idx_ff < HDR_SEQ) begin
               serial_in[{serial_off[1:0], 3'b000} +: 8] = req_byte_in;
            end else if (hdr_idx_ff < HDR_CRC) begin
               seq_in[{seq_off[1:0], 3'b000} +: 8] = req_byte_in;
            end else if (hdr_idx_ff < HDR_SEGS) begin
               crc_in[{crc_off[1:0], 3'b000} +: 8] = req_byte_in;
            end else begin
               segs_in = req_byte_in;
            end
            if (hdr_idx_ff >= HDR_SEGS) begin
               hdr_idx_in = '0;
               lace_in    = req_byte_in;
               pay_in     = '0;
               if (req_byte_in == 8'd0) begin
                  // empty page ends on the segment count
                  out_pend_in = 1'b1;
                  phase_in    = KIND_SIG;
               end else begin
                  phase_in = KIND_LACE;
               end
            end else begin
               hdr_idx_in = hdr_idx_ff + 5'd1;
            end
         end
         KIND_LACE: begin
            out_kind_in = KIND_LACE;
            pay_in      = pay_sum;
            lace_in     = lace_dec;
            if (lace_dec == 8'd0) begin
               if (pay_sum == 16'd0) begin
                  out_pend_in = 1'b1;
                  phase_in    = KIND_SIG;
               end else begin
                  phase_in = KIND_PAY;
               end
            end
         end
         KIND_PAY: begin
            out_kind_in = KIND_PAY;
            pay_in      = pay_dec;
            if (pay_dec == 16'd0) begin
               out_pend_in = 1'b1;
               phase_in    = KIND_SIG;
            end
         end
         default: begin
            // after an error: ignore the byte, keep everything
            out_kind_in = KIND_IGN;
            phase_in    = KIND_IGN;
            consumed    = 1'b0;
         end
      endcase

      // status from the updated error state
      if (phase_in == KIND_IGN) begin
         out_status_in = ST_BAD;
      end else if (req_end_of_data && !out_pend_in) begin
         out_status_in = ST_TRUNC;
      end else begin
         out_status_in = ST_OK;
      end

      // end of data restarts the parser unless it is stuck in error
      if (req_end_of_data && phase_in != KIND_IGN) begin
         phase_in   = KIND_SIG;
         hdr_idx_in = '0;
         lace_in    = '0;
         pay_in     = '0;
      end

      // saturating byte counter
      count_in = count_ff;
      if (consumed && count_ff != {COUNT_WIDTH{1'b1}}) begin
         count_in = count_ff + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
      end
   end

   // clamp the counter to the 32-bit result field
   assign count_wide   = 64'(count_in);
   assign out_count_in = (count_wide > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                : count_wide[31:0];

   always_comb begin
      out_valid_in = out_valid_ff;
      if (accept) begin
         out_valid_in = 1'b1;
      end else if (taken) begin
         out_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= KIND_SIG;
         hdr_idx_ff   <= '0;
         lace_ff      <= '0;
         pay_ff       <= '0;
         version_ff   <= '0;
         flags_ff     <= '0;
         granule_ff   <= '0;
         serial_ff    <= '0;
         seq_ff       <= '0;
         crc_ff       <= '0;
         segs_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (accept) begin
            phase_ff   <= phase_in;
            hdr_idx_ff <= hdr_idx_in;
            lace_ff    <= lace_in;
            pay_ff     <= pay_in;
            version_ff <= version_in;
            flags_ff   <= flags_in;
            granule_ff <= granule_in;
            serial_ff  <= serial_in;
            seq_ff     <= seq_in;
            crc_ff     <= crc_in;
            segs_ff    <= segs_in;
            count_ff   <= count_in;
         end
      end
   end

   // result payload: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         out_kind_ff   <= out_kind_in;
         out_pend_ff   <= out_pend_in;
         out_status_ff <= out_status_in;
         out_count_ff  <= out_count_in;
      end
   end

   // captured fields show the state after the reported byte
   assign rsp_valid          = out_valid_ff;
   assign rsp_byte_kind      = out_kind_ff;
   assign rsp_page_end       = out_pend_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_bytes_consumed = out_count_ff;
   assign rsp_stream_version = version_ff;
   assign rsp_header_flags   = flags_ff;
   assign rsp_granule_pos    = granule_ff;
   assign rsp_serial_no      = serial_ff;
   assign rsp_page_seq       = seq_ff;
   assign rsp_page_crc       = crc_ff;
   assign rsp_segment_count  = segs_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == KIND_IGN |=> phase_ff == KIND_IGN)
      else $error("error state left without reset");

   a_page_end_ok: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_pend_ff |-> out_status_ff == ST_OK)
      else $error("page end reported with bad status");

   a_ignored_bad: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_kind_ff == KIND_IGN |-> out_status_ff == ST_BAD)
      else $error("ignored byte without error status");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |=> out_valid_ff && $stable(out_count_ff))
      else $error("stalled result lost or changed");

endmodule
